[design/swsr_pkg.sv]
`timescale 1ns / 1ps

package swsr_pkg;

  localparam int unsigned FRAME_BITS  = 40;
  localparam int unsigned FRAME_BYTES = FRAME_BITS / 8;
  localparam int unsigned BIT_IDX_W   = 6;
  localparam int unsigned START_W     = 20;
  localparam int unsigned PULSE_W     = 16;
  localparam int unsigned CFG_DATA_W  = 20;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [START_W-1:0] START_LOW_RESET     = START_W'(18000);
  localparam logic [PULSE_W-1:0] PULSE_TIMEOUT_RESET = PULSE_W'(1000);

  localparam logic [CFG_IDX_W-1:0] REG_START_LOW     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_TIMEOUT = 1'b1;

  localparam logic [BIT_IDX_W-1:0] LAST_BIT_COUNT = BIT_IDX_W'(FRAME_BITS);

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_START     = 7'b0000010,
    PH_WAIT_H1   = 7'b0000100,
    PH_WAIT_L    = 7'b0001000,
    PH_WAIT_H2   = 7'b0010000,
    PH_MEAS_LOW  = 7'b0100000,
    PH_MEAS_HIGH = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic                  drive_low;
    logic                  busy_res;
    logic                  done_res;
    logic                  timed_out;
    logic [FRAME_BITS-1:0] frame_bits;
    logic                  checksum_ok;
  } result_t;

  function automatic logic checksum_match(input logic [FRAME_BITS-1:0] bits);
    logic [7:0] sum;
    sum = 8'd0;
    for (int k = 1; k < FRAME_BYTES; k++) begin
      sum = sum + bits[8*k +: 8];
    end
    return sum == bits[7:0];
  endfunction

endpackage

[design/swsr_core.sv]
`timescale 1ns / 1ps

module swsr_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic                             start_req,
  input  logic                             line_level,
  input  logic [swsr_pkg::START_W-1:0]     start_low_ticks,
  input  logic [swsr_pkg::PULSE_W-1:0]     pulse_timeout_ticks,
  output swsr_pkg::result_t                res
);

  localparam logic [swsr_pkg::PULSE_W-1:0] PULSE_ONE = swsr_pkg::PULSE_W'(1);

  swsr_pkg::phase_t                     phase, phase_next, cur;
  logic [swsr_pkg::START_W-1:0]         start_counter, start_counter_next;
  logic [swsr_pkg::PULSE_W-1:0]         low_count, low_count_next;
  logic [swsr_pkg::PULSE_W-1:0]         high_count, high_count_next;
  logic [swsr_pkg::BIT_IDX_W-1:0]       bit_index, bit_index_next;
  logic [swsr_pkg::FRAME_BITS-1:0]      shift_bits, shift_bits_next;
  logic                                 drive, done, tout;
  logic                                 zero_timeout;

  assign zero_timeout = (pulse_timeout_ticks == '0);

  always_comb begin
    phase_next         = phase;
    start_counter_next = start_counter;
    low_count_next     = low_count;
    high_count_next    = high_count;
    bit_index_next     = bit_index;
    shift_bits_next    = shift_bits;
    drive              = 1'b0;
    done               = 1'b0;
    tout               = 1'b0;
    cur                = phase;

    if (phase == swsr_pkg::PH_IDLE && start_req) begin
      cur                = swsr_pkg::PH_START;
      start_counter_next = '0;
      low_count_next     = '0;
      high_count_next    = '0;
      bit_index_next     = '0;
      shift_bits_next    = '0;
    end

    case (cur)
      swsr_pkg::PH_IDLE: begin
        phase_next = swsr_pkg::PH_IDLE;
      end
      swsr_pkg::PH_START: begin
        drive              = 1'b1;
        start_counter_next = start_counter_next + 1'b1;
        if (start_counter_next >= start_low_ticks) begin
          phase_next = swsr_pkg::PH_WAIT_H1;
        end else begin
          phase_next = swsr_pkg::PH_START;
        end
      end
      swsr_pkg::PH_WAIT_H1: begin
        if (!line_level) phase_next = swsr_pkg::PH_WAIT_L;
      end
      swsr_pkg::PH_WAIT_L: begin
        if (line_level) phase_next = swsr_pkg::PH_WAIT_H2;
      end
      swsr_pkg::PH_WAIT_H2: begin
        if (!line_level) begin
          phase_next     = swsr_pkg::PH_MEAS_LOW;
          low_count_next = '0;
          if (zero_timeout) begin
            done = 1'b1;
            tout = 1'b1;
          end else begin
            low_count_next = PULSE_ONE;
          end
        end
      end
      swsr_pkg::PH_MEAS_LOW: begin
        if (!line_level) begin
          if (low_count >= pulse_timeout_ticks) begin
            done = 1'b1;
            tout = 1'b1;
          end else begin
            low_count_next = low_count + 1'b1;
          end
        end else begin
          phase_next      = swsr_pkg::PH_MEAS_HIGH;
          high_count_next = '0;
          if (zero_timeout) begin
            done = 1'b1;
            tout = 1'b1;
          end else begin
            high_count_next = PULSE_ONE;
          end
        end
      end
      swsr_pkg::PH_MEAS_HIGH: begin
        if (line_level) begin
          if (high_count >= pulse_timeout_ticks) begin
            done = 1'b1;
            tout = 1'b1;
          end else begin
            high_count_next = high_count + 1'b1;
          end
        end else begin
          shift_bits_next = {shift_bits[swsr_pkg::FRAME_BITS-2:0], (high_count > low_count)};
          bit_index_next  = bit_index + 1'b1;
          if (bit_index_next >= swsr_pkg::LAST_BIT_COUNT) begin
            done = 1'b1;
          end else begin
            phase_next     = swsr_pkg::PH_MEAS_LOW;
            low_count_next = '0;
            if (zero_timeout) begin
              done = 1'b1;
              tout = 1'b1;
            end else begin
              low_count_next = PULSE_ONE;
            end
          end
        end
      end
      default: begin
        phase_next = swsr_pkg::PH_IDLE;
      end
    endcase

    if (done) phase_next = swsr_pkg::PH_IDLE;
  end

  always_comb begin
    res.drive_low   = drive;
    res.busy_res    = (phase_next != swsr_pkg::PH_IDLE);
    res.done_res    = done;
    res.timed_out   = tout;
    res.frame_bits  = done ? shift_bits_next : '0;
    res.checksum_ok = done && !tout && swsr_pkg::checksum_match(shift_bits_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= swsr_pkg::PH_IDLE;
      start_counter <= '0;
      low_count     <= '0;
      high_count    <= '0;
      bit_index     <= '0;
      shift_bits    <= '0;
    end else if (step) begin
      phase         <= phase_next;
      start_counter <= start_counter_next;
      low_count     <= low_count_next;
      high_count    <= high_count_next;
      bit_index     <= bit_index_next;
      shift_bits    <= shift_bits_next;
    end
  end

endmodule

[design/swsr_out.sv]
`timescale 1ns / 1ps

module swsr_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  swsr_pkg::result_t res_in,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_ready,
  output swsr_pkg::result_t res_out
);

  logic full;

  assign slot_free = !full || out_ready;
  assign out_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

[design/single_wire_sensor_reader_unit.sv]
`timescale 1ns / 1ps
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle while results are taken; the single output
// register accepts a new item in the same cycle its held result is taken.
// Reset: synchronous, active high; the reader returns to idle, counters and the
// received frame clear, and the registers return to 18000 and 1000 ticks.
module single_wire_sensor_reader_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                start_req,
  input  logic                                line_level,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                drive_low,
  output logic                                busy_res,
  output logic                                done_res,
  output logic                                timed_out,
  output logic [swsr_pkg::FRAME_BITS-1:0]     frame_bits,
  output logic                                checksum_ok,
  input  logic                                cfg_we,
  input  logic [swsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swsr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [swsr_pkg::START_W-1:0] start_low_ticks;
  logic [swsr_pkg::PULSE_W-1:0] pulse_timeout_ticks;
  logic                         step;
  swsr_pkg::result_t            res_core, res_held;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_low_ticks     <= swsr_pkg::START_LOW_RESET;
      pulse_timeout_ticks <= swsr_pkg::PULSE_TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        swsr_pkg::REG_START_LOW:     start_low_ticks     <= cfg_wdata[swsr_pkg::START_W-1:0];
        swsr_pkg::REG_PULSE_TIMEOUT: pulse_timeout_ticks <= cfg_wdata[swsr_pkg::PULSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign step = in_valid && in_ready;

  swsr_core u_core (
    .clk                 (clk),
    .rst                 (rst),
    .step                (step),
    .start_req           (start_req),
    .line_level          (line_level),
    .start_low_ticks     (start_low_ticks),
    .pulse_timeout_ticks (pulse_timeout_ticks),
    .res                 (res_core)
  );

  swsr_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_in    (res_core),
    .slot_free (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_held)
  );

  assign drive_low   = res_held.drive_low;
  assign busy_res    = res_held.busy_res;
  assign done_res    = res_held.done_res;
  assign timed_out   = res_held.timed_out;
  assign frame_bits  = res_held.frame_bits;
  assign checksum_ok = res_held.checksum_ok;

endmodule

[bench/single_wire_sensor_reader_unit_test.sv]
`timescale 1ns / 1ps

module single_wire_sensor_reader_unit_test;
  import swsr_pkg::*;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;
  typedef enum {READ_FULL, READ_TIMEOUT, READ_CUT} read_mode_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  start;
    logic                  line;
    logic                  given;
    result_t               want;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  start_req = 1'b0;
  logic                  line_level = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  drive_low;
  logic                  busy_res;
  logic                  done_res;
  logic                  timed_out;
  logic [FRAME_BITS-1:0] frame_bits;
  logic                  checksum_ok;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  step_t   pending_ticks[$];
  result_t expected_results[$];
  step_t   on_wire;
  step_t   plan [19];
  int      sender_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      ticks_queued = 0;
  int      mismatches = 0;

  logic [START_W-1:0]    cfg_pull_len = START_LOW_RESET;
  logic [PULSE_W-1:0]    cfg_pulse_limit = PULSE_TIMEOUT_RESET;
  phase_t                rd_phase = PH_IDLE;
  logic [START_W-1:0]    pull_count = '0;
  logic [PULSE_W-1:0]    low_ticks = '0;
  logic [PULSE_W-1:0]    high_ticks = '0;
  logic [BIT_IDX_W-1:0]  bits_seen = '0;
  logic [FRAME_BITS-1:0] frame_acc = '0;

  single_wire_sensor_reader_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .start_req   (start_req),
    .line_level  (line_level),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .drive_low   (drive_low),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .timed_out   (timed_out),
    .frame_bits  (frame_bits),
    .checksum_ok (checksum_ok),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("single_wire_sensor_reader_unit_test failed");
    $finish;
  end

  task automatic end_reading(input logic to, inout result_t r);
    logic [7:0] sum;
    sum = '0;
    for (int k = 1; k < FRAME_BITS / 8; k++) begin
      sum = sum + frame_acc[8*k +: 8];
    end
    r.done_res = 1'b1;
    r.timed_out = to;
    r.frame_bits = frame_acc;
    r.checksum_ok = !to && (sum == frame_acc[7:0]);
    rd_phase = PH_IDLE;
  endtask

  task automatic count_pulse(inout logic [PULSE_W-1:0] cnt, inout result_t r);
    if (cnt >= cfg_pulse_limit) begin
      end_reading(1'b1, r);
    end else begin
      cnt = cnt + 1'b1;
    end
  endtask

  task automatic predict_reading_tick(input logic start, input logic line,
                                      output result_t r);
    r = '0;
    if (rd_phase == PH_IDLE && start) begin
      rd_phase = PH_START;
      pull_count = '0;
      low_ticks = '0;
      high_ticks = '0;
      bits_seen = '0;
      frame_acc = '0;
    end
    case (rd_phase)
      PH_START: begin
        r.drive_low = 1'b1;
        pull_count = pull_count + 1'b1;
        if (pull_count >= cfg_pull_len) rd_phase = PH_WAIT_H1;
      end
      PH_WAIT_H1: begin
        if (!line) rd_phase = PH_WAIT_L;
      end
      PH_WAIT_L: begin
        if (line) rd_phase = PH_WAIT_H2;
      end
      PH_WAIT_H2: begin
        if (!line) begin
          rd_phase = PH_MEAS_LOW;
          low_ticks = '0;
          count_pulse(low_ticks, r);
        end
      end
      PH_MEAS_LOW: begin
        if (!line) begin
          count_pulse(low_ticks, r);
        end else begin
          rd_phase = PH_MEAS_HIGH;
          high_ticks = '0;
          count_pulse(high_ticks, r);
        end
      end
      PH_MEAS_HIGH: begin
        if (line) begin
          count_pulse(high_ticks, r);
        end else begin
          frame_acc = {frame_acc[FRAME_BITS-2:0], high_ticks > low_ticks};
          bits_seen = bits_seen + 1'b1;
          if (bits_seen >= LAST_BIT_COUNT) begin
            end_reading(1'b0, r);
          end else begin
            rd_phase = PH_MEAS_LOW;
            low_ticks = '0;
            count_pulse(low_ticks, r);
          end
        end
      end
      default: begin
      end
    endcase
    r.busy_res = (rd_phase != PH_IDLE);
  endtask

  function automatic step_t free_tick(input int s, input int l);
    step_t st;
    st = '0;
    st.kind = ROW_ITEM;
    st.start = s[0];
    st.line = l[0];
    return st;
  endfunction

  function automatic step_t given_tick(input int s, input int l, input int d,
                                       input int b, input int dn, input int to);
    step_t st;
    st = free_tick(s, l);
    st.given = 1'b1;
    st.want.drive_low = d[0];
    st.want.busy_res = b[0];
    st.want.done_res = dn[0];
    st.want.timed_out = to[0];
    return st;
  endfunction

  function automatic step_t reg_step(input logic [CFG_IDX_W-1:0] idx,
                                     input int val);
    step_t st;
    st = '0;
    st.kind = ROW_WRITE;
    st.reg_index = idx;
    st.reg_value = CFG_DATA_W'(val);
    return st;
  endfunction

  function automatic logic [FRAME_BITS-1:0] any_frame();
    logic [FRAME_BITS-1:0] f;
    logic [7:0]            sum;
    f = FRAME_BITS'({$urandom, $urandom});
    if ($urandom_range(1) == 1) begin
      sum = '0;
      for (int k = 1; k < FRAME_BITS / 8; k++) begin
        sum = sum + f[8*k +: 8];
      end
      f[7:0] = sum;
    end
    return f;
  endfunction

  task automatic push_tick(input int s, input int l);
    pending_ticks.push_back(free_tick(s, l));
    ticks_queued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_START_LOW) begin
      cfg_pull_len = val[START_W-1:0];
    end else begin
      cfg_pulse_limit = val[PULSE_W-1:0];
    end
  endtask

  // Waits until every result is in, then forces an unfinished reading to end.
  task automatic settle();
    forever begin
      @(negedge clk);
      if (pending_ticks.size() == 0 && !in_valid && expected_results.size() == 0) begin
        if (rd_phase == PH_IDLE) break;
        push_tick(1'b0, 1'b1);
        repeat (int'(cfg_pulse_limit) + 2) push_tick(1'b0, 1'b0);
      end
    end
    repeat (2) @(negedge clk);
  endtask

  task automatic set_timing(input int pull, input int limit);
    settle();
    write_reg(REG_START_LOW, CFG_DATA_W'(pull));
    write_reg(REG_PULSE_TIMEOUT, CFG_DATA_W'(limit));
  endtask

  task automatic gen_reading(input logic [FRAME_BITS-1:0] data, input int wmax,
                             input read_mode_t mode);
    int   cap;
    int   lo;
    int   hi;
    int   stop_bit;
    int   idx;
    logic stop_high;
    cap = (wmax < int'(cfg_pulse_limit)) ? wmax : int'(cfg_pulse_limit);
    if (cap < 1) cap = 1;
    stop_bit = $urandom_range(FRAME_BITS - 1);
    stop_high = ($urandom_range(1) == 1);
    push_tick(1'b1, $urandom_range(1));
    for (int i = 1; i < int'(cfg_pull_len); i++) begin
      push_tick($urandom_range(1), $urandom_range(1));
    end
    repeat ($urandom_range(0, 3)) push_tick($urandom_range(1), 1'b1);
    repeat ($urandom_range(1, 3)) push_tick($urandom_range(1), 1'b0);
    repeat ($urandom_range(1, 3)) push_tick($urandom_range(1), 1'b1);
    for (int b = FRAME_BITS - 1; b >= 0; b--) begin
      idx = FRAME_BITS - 1 - b;
      if (data[b] && cap >= 2) begin
        lo = $urandom_range(1, cap - 1);
        hi = $urandom_range(lo + 1, cap);
      end else begin
        lo = $urandom_range(1, cap);
        hi = $urandom_range(1, lo);
      end
      if (mode == READ_TIMEOUT && idx == stop_bit) begin
        if (stop_high) begin
          repeat (lo) push_tick($urandom_range(1), 1'b0);
          repeat (int'(cfg_pulse_limit) + 1) push_tick($urandom_range(1), 1'b1);
        end else begin
          repeat (int'(cfg_pulse_limit) + 1) push_tick($urandom_range(1), 1'b0);
        end
        return;
      end
      repeat (lo) push_tick($urandom_range(1), 1'b0);
      if (mode == READ_CUT && idx == stop_bit) return;
      repeat (hi) push_tick($urandom_range(1), 1'b1);
    end
    // The request on the closing sample must be ignored.
    push_tick(1'b1, 1'b0);
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct, input int pull,
                              input int limit, input int wmax, input int quota);
    int first;
    int pick;
    set_timing(pull, limit);
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    first = ticks_queued;
    while (ticks_queued - first < quota) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        gen_reading(any_frame(), wmax, READ_FULL);
      end else if (pick < 80) begin
        gen_reading(any_frame(), wmax, READ_TIMEOUT);
      end else if (pick < 90) begin
        gen_reading(any_frame(), wmax, READ_CUT);
      end else begin
        repeat ($urandom_range(1, 20)) begin
          push_tick($urandom_range(7) == 0, $urandom_range(1));
        end
      end
    end
  endtask

  task automatic flag_field(input string field, input logic [63:0] want,
                            input logic [63:0] got);
    if (mismatches < 30) begin
      $display("%0t %s expected %0h got %0h", $time, field, want, got);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : feed_ticks
    step_t   next_tick;
    result_t predicted;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_reading_tick(on_wire.start, on_wire.line, predicted);
        expected_results.push_back(on_wire.given ? on_wire.want : predicted);
      end
      if (!in_valid || in_ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_tick = pending_ticks.pop_front();
          on_wire <= next_tick;
          start_req <= next_tick.start;
          line_level <= next_tick.line;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : take_results
    result_t want;
    result_t got;
    if (!rst && out_valid && out_ready) begin
      got = {drive_low, busy_res, done_res, timed_out, frame_bits, checksum_ok};
      if (expected_results.size() == 0) begin
        if (mismatches < 30) $display("%0t unexpected result %0h", $time, got);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got.drive_low !== want.drive_low)
          flag_field("drive_low", want.drive_low, got.drive_low);
        if (got.busy_res !== want.busy_res)
          flag_field("busy_res", want.busy_res, got.busy_res);
        if (got.done_res !== want.done_res)
          flag_field("done_res", want.done_res, got.done_res);
        if (got.timed_out !== want.timed_out)
          flag_field("timed_out", want.timed_out, got.timed_out);
        if (got.frame_bits !== want.frame_bits)
          flag_field("frame_bits", want.frame_bits, got.frame_bits);
        if (got.checksum_ok !== want.checksum_ok)
          flag_field("checksum_ok", want.checksum_ok, got.checksum_ok);
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    plan = '{
      reg_step(REG_START_LOW, 0),
      reg_step(REG_PULSE_TIMEOUT, 0),
      given_tick(1, 0, 1, 1, 0, 0),
      given_tick(1, 1, 0, 1, 0, 0),
      given_tick(0, 0, 0, 1, 0, 0),
      given_tick(0, 1, 0, 1, 0, 0),
      given_tick(1, 0, 0, 0, 1, 1),
      given_tick(0, 1, 0, 0, 0, 0),
      reg_step(REG_START_LOW, 2),
      reg_step(REG_PULSE_TIMEOUT, 1),
      given_tick(1, 1, 1, 1, 0, 0),
      given_tick(1, 0, 1, 1, 0, 0),
      free_tick(0, 1),
      free_tick(1, 0),
      free_tick(0, 1),
      free_tick(0, 0),
      free_tick(1, 1),
      given_tick(0, 1, 0, 0, 1, 1),
      given_tick(0, 0, 0, 0, 0, 0)
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Idle after reset.
    pending_ticks.push_back(given_tick(0, 1, 0, 0, 0, 0));
    pending_ticks.push_back(given_tick(0, 0, 0, 0, 0, 0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].reg_index, plan[i].reg_value);
      end else begin
        pending_ticks.push_back(plan[i]);
      end
    end

    set_timing(1, 8);
    gen_reading('1, 4, READ_FULL);
    gen_reading('0, 4, READ_FULL);

    random_phase(0, 0, 3, 5, 5, 300);
    random_phase(75, 0, 1, 2, 2, 280);
    random_phase(0, 75, 12, 20, 8, 300);
    random_phase(16, 16, 0, 7, 7, 280);

    set_timing(4, 65535);
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    gen_reading(any_frame(), 6, READ_FULL);

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("single_wire_sensor_reader_unit_test passed");
    end else begin
      $display("single_wire_sensor_reader_unit_test failed");
    end
    $finish;
  end

endmodule

[files.f]
design/swsr_pkg.sv
design/swsr_core.sv
design/swsr_out.sv
design/single_wire_sensor_reader_unit.sv
bench/single_wire_sensor_reader_unit_test.sv
